/* design/dqke_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dqke_pkg
// Shared types and constants for the DNS query key extractor.
// -----------------------------------------------------------------------------
package dqke_pkg;

   localparam int unsigned NAME_MAX_BYTES = 256;

   localparam logic [9:0]  OFF_ETYPE_LO   = 10'd13;
   localparam logic [9:0]  OFF_IP_VER_IHL = 10'd14;
   localparam logic [9:0]  OFF_IP_PROTO   = 10'd23;
   localparam logic [9:0]  OFF_IP_LAST    = 10'd33;
   localparam logic [9:0]  OFF_UDP_DPORT  = 10'd37;
   localparam logic [9:0]  OFF_UDP_LAST   = 10'd41;
   localparam logic [9:0]  OFF_TXID_HI    = 10'd42;
   localparam logic [9:0]  OFF_TXID_LO    = 10'd43;
   localparam logic [9:0]  OFF_DNS_FLAGS  = 10'd44;
   localparam logic [9:0]  OFF_QDCOUNT_LO = 10'd47;
   localparam logic [9:0]  OFF_DNS_LAST   = 10'd53;
   localparam logic [9:0]  OFF_NAME_START = 10'd54;
   localparam logic [9:0]  OFF_MAX        = 10'd1023;

   localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
   localparam logic [3:0]  IP_IHL_PLAIN     = 4'd5;
   localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
   localparam logic [15:0] QUERY_PORT_RESET = 16'd53;
   localparam logic [8:0]  KEY_LIMIT        = 9'(NAME_MAX_BYTES);

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_TRUNC    = 4'd1,
      ST_NOT_IP4  = 4'd2,
      ST_IP_OPTS  = 4'd3,
      ST_NOT_UDP  = 4'd4,
      ST_PORT     = 4'd5,
      ST_RESPONSE = 4'd6,
      ST_QDCOUNT  = 4'd7,
      ST_LABEL    = 4'd8,
      ST_LONG     = 4'd9
   } status_type;

   typedef enum logic {
      KIND_KEY     = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_QUERY_PORT = 2'd0
   } csr_addr_type;

   typedef struct packed {
      logic [8:0]  key_length;
      logic [15:0] transaction_id;
      logic [15:0] query_type;
      status_type  status;
      logic [7:0]  key_index;
      logic [7:0]  key_byte;
   } rsp_data_type;

   typedef struct packed {
      kind_type     kind;
      rsp_data_type data;
   } rsp_item_type;

endpackage

/* design/dqke_csr.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dqke_csr
// APB-style register file holding the DNS destination port.
// -----------------------------------------------------------------------------
module dqke_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] query_port
);
   import dqke_pkg::*;

   logic [15:0] query_port_ff;
   logic [15:0] query_port_in;
   logic        wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == CSR_QUERY_PORT);

   always_comb begin
      query_port_in = query_port_ff;
      if (wr_hit) begin
         query_port_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_port_ff <= QUERY_PORT_RESET;
      end else begin
         query_port_ff <= query_port_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_QUERY_PORT) ? {16'd0, query_port_ff} : 32'd0;
   assign query_port = query_port_ff;

endmodule

/* design/dqke_parser.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dqke_parser
// Per-byte header checks and query name walk; one byte per step.
// -----------------------------------------------------------------------------
module dqke_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  frame_end,
   input  logic [15:0]           query_port,
   output logic                  res_valid,
   output dqke_pkg::rsp_item_type res_item
);
   import dqke_pkg::*;

   logic [9:0]  byte_offset_ff, byte_offset_in;
   logic [5:0]  label_rem_ff, label_rem_in;
   logic [8:0]  key_count_ff, key_count_in;
   logic        name_end_ff, name_end_in;
   logic        decided_ff, decided_in;
   status_type  status_ff, status_in;
   logic [15:0] txid_ff, txid_in;
   logic [15:0] qtype_ff, qtype_in;
   logic [1:0]  post_cnt_ff, post_cnt_in;
   logic [7:0]  last_byte_ff, last_byte_in;
   status_type  pending_ff, pending_in;

   logic [15:0] word;
   logic        emit;
   logic [7:0]  kbyte;
   logic [7:0]  kidx;

   assign word = {last_byte_ff, data_byte};

   always_comb begin
      byte_offset_in = byte_offset_ff;
      label_rem_in   = label_rem_ff;
      key_count_in   = key_count_ff;
      name_end_in    = name_end_ff;
      decided_in     = decided_ff;
      status_in      = status_ff;
      txid_in        = txid_ff;
      qtype_in       = qtype_ff;
      post_cnt_in    = post_cnt_ff;
      last_byte_in   = last_byte_ff;
      pending_in     = pending_ff;
      emit           = 1'b0;
      kbyte          = 8'd0;
      kidx           = 8'd0;
      res_valid      = 1'b0;
      res_item       = '0;

      if (step) begin
         if (!decided_ff) begin
            if (byte_offset_ff < OFF_NAME_START) begin
               case (byte_offset_ff)
                  OFF_ETYPE_LO: begin
                     if (word != ETHERTYPE_IPV4) begin
                        decided_in = 1'b1;
                        status_in  = ST_NOT_IP4;
                     end
                  end
                  OFF_IP_VER_IHL: begin
                     if (data_byte[3:0] != IP_IHL_PLAIN) pending_in = ST_IP_OPTS;
                  end
                  OFF_IP_PROTO: begin
                     if (data_byte != IP_PROTO_UDP && pending_ff == ST_OK)
                        pending_in = ST_NOT_UDP;
                  end
                  OFF_UDP_DPORT: begin
                     if (word != query_port) pending_in = ST_PORT;
                  end
                  OFF_TXID_HI: txid_in = {data_byte, 8'd0};
                  OFF_TXID_LO: txid_in = word;
                  OFF_DNS_FLAGS: begin
                     if (data_byte[7]) pending_in = ST_RESPONSE;
                  end
                  OFF_QDCOUNT_LO: begin
                     if (word != 16'd1 && pending_ff == ST_OK) pending_in = ST_QDCOUNT;
                  end
                  OFF_IP_LAST, OFF_UDP_LAST, OFF_DNS_LAST: begin
                     if (pending_ff != ST_OK) begin
                        decided_in = 1'b1;
                        status_in  = pending_ff;
                     end
                     pending_in = ST_OK;
                  end
                  default: ;
               endcase
            end else if (!name_end_ff) begin
               if (label_rem_ff == 6'd0) begin
                  if (data_byte[7:6] != 2'd0) begin
                     decided_in = 1'b1;
                     status_in  = ST_LABEL;
                  end else begin
                     emit  = 1'b1;
                     kbyte = data_byte;
                     if (data_byte == 8'd0) name_end_in = 1'b1;
                     else label_rem_in = data_byte[5:0];
                  end
               end else begin
                  emit  = 1'b1;
                  kbyte = (data_byte >= 8'h41 && data_byte <= 8'h5A)
                          ? data_byte + 8'd32 : data_byte;
                  label_rem_in = label_rem_ff - 6'd1;
               end
               if (emit) begin
                  kidx         = key_count_ff[7:0];
                  key_count_in = key_count_ff + 9'd1;
                  if (!name_end_in && key_count_in >= KEY_LIMIT) begin
                     decided_in = 1'b1;
                     status_in  = ST_LONG;
                  end
               end
            end else begin
               case (post_cnt_ff)
                  2'd0: qtype_in = {data_byte, 8'd0};
                  2'd1: qtype_in = {qtype_ff[15:8], data_byte};
                  2'd3: begin
                     decided_in = 1'b1;
                     status_in  = ST_OK;
                  end
                  default: ;
               endcase
               if (post_cnt_ff != 2'd3) post_cnt_in = post_cnt_ff + 2'd1;
            end
            last_byte_in = data_byte;
            if (byte_offset_ff != OFF_MAX) byte_offset_in = byte_offset_ff + 10'd1;
         end

         if (frame_end) begin
            res_valid                    = 1'b1;
            res_item.kind                = KIND_VERDICT;
            res_item.data.status         = status_in;
            res_item.data.query_type     = (status_in == ST_OK) ? qtype_in : 16'd0;
            res_item.data.transaction_id = txid_in;
            res_item.data.key_length     = key_count_in;
            byte_offset_in = '0;
            label_rem_in   = '0;
            key_count_in   = '0;
            name_end_in    = 1'b0;
            decided_in     = 1'b0;
            status_in      = ST_TRUNC;
            txid_in        = '0;
            qtype_in       = '0;
            post_cnt_in    = '0;
            last_byte_in   = '0;
            pending_in     = ST_OK;
         end else if (emit) begin
            res_valid               = 1'b1;
            res_item.kind           = KIND_KEY;
            res_item.data.key_byte  = kbyte;
            res_item.data.key_index = kidx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         label_rem_ff   <= '0;
         key_count_ff   <= '0;
         name_end_ff    <= 1'b0;
         decided_ff     <= 1'b0;
         status_ff      <= ST_TRUNC;
         txid_ff        <= '0;
         qtype_ff       <= '0;
         post_cnt_ff    <= '0;
         last_byte_ff   <= '0;
         pending_ff     <= ST_OK;
      end else begin
         byte_offset_ff <= byte_offset_in;
         label_rem_ff   <= label_rem_in;
         key_count_ff   <= key_count_in;
         name_end_ff    <= name_end_in;
         decided_ff     <= decided_in;
         status_ff      <= status_in;
         txid_ff        <= txid_in;
         qtype_ff       <= qtype_in;
         post_cnt_ff    <= post_cnt_in;
         last_byte_ff   <= last_byte_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

/* design/dns_query_key_extractor_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dns_query_key_extractor_top
// Streams Ethernet frames byte by byte and extracts the DNS query name key.
// -----------------------------------------------------------------------------
// Each request is one frame byte (tlast on the final byte). A byte is held in
// an input register and judged, when the result register is free or draining,
// against the Ethernet, IPv4, UDP and DNS header fields; name bytes come out
// as key items (tuser 0) and the final byte of a frame yields one verdict item
// (tuser 1) with status, qtype, transaction id and key length. One request
// per cycle is sustained unless rsp_tready stalls; a result passes the input
// and result registers. Bytes after a decision yield nothing until the verdict.
// -----------------------------------------------------------------------------
module dns_query_key_extractor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // key_byte, key_index, status, query_type,
                                    // transaction_id, key_length, zero pad
   output logic        rsp_tuser,   // kind
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dqke_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_data_ff, in_data_in;
   logic         in_last_ff, in_last_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         advance;
   logic         step;
   logic         res_valid;
   rsp_item_type res_item;
   logic [15:0]  query_port;

   dqke_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .query_port  (query_port)
   );

   dqke_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_data_ff),
      .frame_end  (in_last_ff),
      .query_port (query_port),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   // result register free or draining this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      in_last_in   = in_last_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = res_valid;
         if (res_valid) out_item_in = res_item;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      in_last_ff  <= in_last_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_item_ff.data};
   assign rsp_tuser  = out_item_ff.kind;

   a_key_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_KEY) |->
         (out_item_ff.data.status == ST_OK && out_item_ff.data.key_length == 9'd0))
      else $error("key item carries verdict fields");

   a_qtype_only_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item_ff.data.status != ST_OK) |->
         (out_item_ff.data.query_type == 16'd0))
      else $error("qtype reported on a failed frame");

   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)
         && $stable(in_last_ff)))
      else $error("input register lost a byte under stall");

   a_verdict_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_VERDICT) |->
         (out_item_ff.data.key_byte == 8'd0 && out_item_ff.data.key_index == 8'd0))
      else $error("verdict carries key byte fields");

endmodule
